// ===== hw/rtl/mqfe_pkg.sv =====
// Shared types and constants of the multi-queue FIFO engine.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package mqfe_pkg;

	// Default sizes for the top-level parameters
	localparam int NUM_QUEUES_DEF = 256;
	localparam int MAX_DEPTH_DEF  = 128;
	localparam int DATA_WIDTH_DEF = 64;

	// Port field widths
	localparam int QID_W       = 8;
	localparam int TID_W       = 8;
	localparam int WORD_W      = 64;
	localparam int FREE_W      = 7;
	localparam int QCOUNT_W    = 9;
	localparam int DSEL_W      = 3;
	localparam int CFG_DATA_W  = 9;
	localparam int IN_TDATA_W  = 80;
	localparam int OUT_TDATA_W = 80;

	// Queue depth for each depth_select code
	localparam logic [7:0] DEPTH_TABLE [8] = '{
		8'd8, 8'd12, 8'd32, 8'd48, 8'd64, 8'd80, 8'd96, 8'd128
	};

	typedef enum logic [2:0] {
		REQ_PRODUCE    = 3'd0,
		REQ_CONSUME    = 3'd1,
		REQ_PEEK       = 3'd2,
		REQ_OPEN_PROD  = 3'd3,
		REQ_OPEN_CONS  = 3'd4,
		REQ_CLOSE_PROD = 3'd5,
		REQ_CLOSE_CONS = 3'd6
	} req_t;

	typedef enum logic [2:0] {
		STS_OK        = 3'd0,
		STS_FULL      = 3'd1,
		STS_EMPTY     = 3'd2,
		STS_BUSY      = 3'd3,
		STS_NOT_OWNER = 3'd4,
		STS_BAD_QUEUE = 3'd5
	} status_t;

	typedef enum logic {
		CFG_QUEUE_COUNT = 1'b0,
		CFG_DEPTH_SEL   = 1'b1
	} cfg_reg_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_EXEC,
		ST_FINISH
	} state_t;

	typedef struct packed {
		logic             vld;
		logic [TID_W-1:0] tid;
	} owner_t;

	// Read/write requests from the control logic to the queue state memory
	typedef struct packed {
		logic rd_en;
		logic wr_en;
		logic clr;
	} meta_ctl_t;

endpackage

// ===== hw/rtl/mqfe_meta_store.sv =====
// Per-queue state memory (pointers and owners) with one valid flag per entry.
// An entry never written since reset or the last clear reads as all zero.
// Depends on mqfe_pkg.
`timescale 1ns / 1ps

module mqfe_meta_store import mqfe_pkg::*; #(
	parameter int DEPTH = NUM_QUEUES_DEF,
	parameter int AW    = 8,
	parameter int WIDTH = 32
) (
	input  logic             clk,
	input  logic             arst_n,
	input  meta_ctl_t        ctl,
	input  logic [AW-1:0]    rd_addr,
	input  logic [AW-1:0]    wr_addr,
	input  logic [WIDTH-1:0] wr_data,
	output logic [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [DEPTH-1:0] vld_q;
	logic [WIDTH-1:0] rd_data_q;
	logic             rd_vld_q;

	always_ff @(posedge clk) begin
		if (ctl.wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (ctl.rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q    <= '0;
			rd_vld_q <= 1'b0;
		end else begin
			if (ctl.clr) begin
				vld_q <= '0;
			end else if (ctl.wr_en) begin
				vld_q[wr_addr] <= 1'b1;
			end
			if (ctl.rd_en) begin
				rd_vld_q <= vld_q[rd_addr];
			end
		end
	end

	assign rd_data = rd_vld_q ? rd_data_q : '0;

endmodule

// ===== hw/rtl/mqfe_entry_ram.sv =====
// Single-port word store shared by all queues, with a registered read.
// Depends on mqfe_pkg.
`timescale 1ns / 1ps

module mqfe_entry_ram import mqfe_pkg::*; #(
	parameter int DEPTH = NUM_QUEUES_DEF * MAX_DEPTH_DEF,
	parameter int AW    = 15,
	parameter int WIDTH = DATA_WIDTH_DEF
) (
	input  logic             clk,
	input  logic             en,
	input  logic             we,
	input  logic [AW-1:0]    addr,
	input  logic [WIDTH-1:0] wdata,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (en) begin
			if (we) begin
				mem[addr] <= wdata;
			end else begin
				rdata <= mem[addr];
			end
		end
	end

endmodule

// ===== hw/rtl/multi_queue_fifo_engine_core.sv =====
// Multi-queue FIFO engine: up to NUM_QUEUES circular queues of words with
// producer/consumer ownership. A request is accepted in the cycle its queue
// state is read from the state memory; the next cycle checks ownership and
// occupancy, writes the state back and reads or writes the word store; the
// finish state then places the response in the output register and may accept
// the next request. A new request is taken only once the previous one has
// reached the finish state, set by the state-memory read-modify-write followed
// by the word-store read addressed by the fetched read pointer. A full
// output register that is not taken stalls the input. A write to either
// configuration register empties every queue and drops all owners at once
// (stored words stay); no clearing pass runs after reset. Busy queues
// answer with a retry or busy status, never wait.
// Depends on mqfe_pkg, mqfe_meta_store and mqfe_entry_ram.
`timescale 1ns / 1ps

module multi_queue_fifo_engine_core import mqfe_pkg::*; #(
	parameter int NUM_QUEUES = NUM_QUEUES_DEF,
	parameter int MAX_DEPTH  = MAX_DEPTH_DEF,
	parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	// slave side
	input  logic                   s_axis_tvalid,
	output logic                   s_axis_tready,
	// [7:0] queue_id, [15:8] thread_id, [79:16] write_data
	input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
	// [2:0] req_type
	input  logic [2:0]             s_axis_tuser,
	// master side
	output logic                   m_axis_tvalid,
	input  logic                   m_axis_tready,
	// [63:0] read_data, [64] queue empty, [65] is_full, [72:66] free_slots, [79:73] zero
	output logic [OUT_TDATA_W-1:0] m_axis_tdata,
	// [2:0] status
	output logic [2:0]             m_axis_tuser,
	// configuration
	input  logic                   cfg_wr_en,
	input  logic                   cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_wdata
);

	localparam int QW   = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
	localparam int PW   = $clog2(MAX_DEPTH);
	localparam int DW   = $clog2(MAX_DEPTH + 1);
	localparam int FW   = (DW > FREE_W) ? DW : FREE_W;
	localparam int CW   = ($clog2(NUM_QUEUES + 1) > QCOUNT_W) ?
		$clog2(NUM_QUEUES + 1) : QCOUNT_W;
	localparam int MW   = 2 * PW + 2 * $bits(owner_t);
	localparam int EAW  = QW + PW;
	localparam int EDEP = NUM_QUEUES * (2 ** PW);

	// configuration
	logic [QCOUNT_W-1:0] queue_count_q;
	logic [DSEL_W-1:0]   depth_sel_q;

	// request held across the pipeline
	req_t                  req_s1;
	logic [QID_W-1:0]      qid_s1;
	logic [TID_W-1:0]      tid_s1;
	logic [DATA_WIDTH-1:0] wdata_s1;

	// response fields computed in the execute cycle
	status_t         sts_s2;
	logic            use_rd_s2;
	logic            empty_s2;
	logic            full_s2;
	logic [FREE_W-1:0] free_s2;

	// output register
	logic              out_valid_q;
	status_t           out_sts_q;
	logic [WORD_W-1:0] out_rdata_q;
	logic              out_empty_q;
	logic              out_full_q;
	logic [FREE_W-1:0] out_free_q;

	state_t state_q, state_nxt;
	logic   in_rdy, accept, out_free, out_load, exec;

	meta_ctl_t        meta_ctl;
	logic [MW-1:0]    meta_rdata, meta_wdata;
	logic [QW-1:0]    qidx_s1;

	logic                  ent_en, ent_we;
	logic [EAW-1:0]        ent_addr;
	logic [DATA_WIDTH-1:0] ent_rdata;

	// decoded state of the addressed queue
	logic [PW-1:0] wp, rp, wp_nxt, rp_nxt;
	owner_t        prod, cons, prod_nxt, cons_nxt;
	logic [DW-1:0] depth;
	logic [10:0]   tbl_depth;
	logic          bad, empty, full, use_rd;
	status_t       sts;
	logic [FW-1:0] wpx, rpx, free_cnt;

	function automatic logic [PW-1:0] adv(input logic [PW-1:0] p, input logic [DW-1:0] d);
		logic [DW-1:0] n;
		n = DW'(p) + DW'(1);
		return (n >= d) ? '0 : PW'(n);
	endfunction

	// ---------------------------------------------------------------------
	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			queue_count_q <= QCOUNT_W'(1);
			depth_sel_q   <= '0;
		end else if (cfg_wr_en) begin
			unique case (cfg_reg_t'(cfg_index))
				CFG_QUEUE_COUNT: queue_count_q <= cfg_wdata[QCOUNT_W-1:0];
				CFG_DEPTH_SEL:   depth_sel_q   <= cfg_wdata[DSEL_W-1:0];
				default:         ;
			endcase
		end
	end

	// ---------------------------------------------------------------------
	// Control FSM
	assign out_free = !out_valid_q || m_axis_tready;
	assign accept   = s_axis_tvalid && in_rdy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					state_nxt = ST_EXEC;
				end
			end
			ST_EXEC: begin
				state_nxt = ST_FINISH;
			end
			ST_FINISH: begin
				if (out_free) begin
					state_nxt = accept ? ST_EXEC : ST_IDLE;
				end
			end
			default: state_nxt = ST_IDLE;
		endcase
	end

	always_comb begin
		in_rdy   = 1'b0;
		exec     = 1'b0;
		out_load = 1'b0;
		unique case (state_q)
			ST_IDLE:   in_rdy = 1'b1;
			ST_EXEC:   exec   = 1'b1;
			ST_FINISH: begin
				in_rdy   = out_free;
				out_load = out_free;
			end
			default: ;
		endcase
	end

	assign s_axis_tready = in_rdy;

	// ---------------------------------------------------------------------
	// Capture the request
	always_ff @(posedge clk) begin
		if (accept) begin
			req_s1   <= req_t'(s_axis_tuser);
			qid_s1   <= s_axis_tdata[7:0];
			tid_s1   <= s_axis_tdata[15:8];
			wdata_s1 <= s_axis_tdata[16 +: DATA_WIDTH];
		end
	end

	assign qidx_s1 = QW'(qid_s1);

	// ---------------------------------------------------------------------
	// Queue state memory
	assign meta_ctl.rd_en = accept;
	assign meta_ctl.clr   = cfg_wr_en;

	mqfe_meta_store #(
		.DEPTH (NUM_QUEUES),
		.AW    (QW),
		.WIDTH (MW)
	) u_meta (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl     (meta_ctl),
		.rd_addr (QW'(s_axis_tdata[7:0])),
		.wr_addr (qidx_s1),
		.wr_data (meta_wdata),
		.rd_data (meta_rdata)
	);

	assign {cons, prod, rp, wp} = meta_rdata;

	// ---------------------------------------------------------------------
	// Execute: check the request against the fetched queue state
	assign tbl_depth = {3'b000, DEPTH_TABLE[depth_sel_q]};
	assign depth     = (tbl_depth > 11'(MAX_DEPTH)) ? DW'(MAX_DEPTH) : DW'(tbl_depth);
	assign bad       = (CW'(qid_s1) >= CW'(queue_count_q)) || (CW'(qid_s1) >= CW'(NUM_QUEUES));

	always_comb begin
		sts      = STS_OK;
		wp_nxt   = wp;
		rp_nxt   = rp;
		prod_nxt = prod;
		cons_nxt = cons;
		use_rd   = 1'b0;
		ent_we   = 1'b0;
		case (req_s1)
			REQ_PRODUCE: begin
				if (!prod.vld || prod.tid != tid_s1) begin
					sts = STS_NOT_OWNER;
				end else if (adv(wp, depth) == rp) begin
					sts = STS_FULL;
				end else begin
					ent_we = 1'b1;
					wp_nxt = adv(wp, depth);
				end
			end
			REQ_CONSUME: begin
				if (!cons.vld || cons.tid != tid_s1) begin
					sts = STS_NOT_OWNER;
				end else if (wp == rp) begin
					sts = STS_EMPTY;
				end else begin
					use_rd = 1'b1;
					rp_nxt = adv(rp, depth);
				end
			end
			REQ_PEEK: begin
				if (wp == rp) begin
					sts = STS_EMPTY;
				end else begin
					use_rd = 1'b1;
				end
			end
			REQ_OPEN_PROD: begin
				if (prod.vld) begin
					sts = STS_BUSY;
				end else begin
					prod_nxt = '{vld: 1'b1, tid: tid_s1};
				end
			end
			REQ_OPEN_CONS: begin
				if (cons.vld) begin
					sts = STS_BUSY;
				end else begin
					cons_nxt = '{vld: 1'b1, tid: tid_s1};
				end
			end
			REQ_CLOSE_PROD: begin
				if (!prod.vld || prod.tid != tid_s1) begin
					sts = STS_NOT_OWNER;
				end else begin
					prod_nxt = '0;
				end
			end
			REQ_CLOSE_CONS: begin
				if (!cons.vld || cons.tid != tid_s1) begin
					sts = STS_NOT_OWNER;
				end else begin
					cons_nxt = '0;
				end
			end
			default: ;
		endcase
	end

	// occupancy after the request
	assign empty    = (wp_nxt == rp_nxt);
	assign full     = (adv(wp_nxt, depth) == rp_nxt);
	assign wpx      = FW'(wp_nxt);
	assign rpx      = FW'(rp_nxt);
	assign free_cnt = (wp_nxt >= rp_nxt) ? (FW'(depth) - FW'(1) - (wpx - rpx)) :
		(rpx - wpx - FW'(1));

	assign meta_ctl.wr_en = exec && !bad;
	assign meta_wdata     = {cons_nxt, prod_nxt, rp_nxt, wp_nxt};

	// ---------------------------------------------------------------------
	// Word store
	assign ent_en   = exec && !bad && (ent_we || use_rd);
	assign ent_addr = {qidx_s1, ent_we ? wp : rp};

	mqfe_entry_ram #(
		.DEPTH (EDEP),
		.AW    (EAW),
		.WIDTH (DATA_WIDTH)
	) u_entry (
		.clk   (clk),
		.en    (ent_en),
		.we    (ent_we),
		.addr  (ent_addr),
		.wdata (wdata_s1),
		.rdata (ent_rdata)
	);

	always_ff @(posedge clk) begin
		if (exec) begin
			if (bad) begin
				sts_s2    <= STS_BAD_QUEUE;
				use_rd_s2 <= 1'b0;
				empty_s2  <= 1'b0;
				full_s2   <= 1'b0;
				free_s2   <= '0;
			end else begin
				sts_s2    <= sts;
				use_rd_s2 <= use_rd;
				empty_s2  <= empty;
				full_s2   <= full;
				free_s2   <= free_cnt[FREE_W-1:0];
			end
		end
	end

	// ---------------------------------------------------------------------
	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_sts_q   <= sts_s2;
			out_rdata_q <= use_rd_s2 ? WORD_W'(ent_rdata) : '0;
			out_empty_q <= empty_s2;
			out_full_q  <= full_s2;
			out_free_q  <= free_s2;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tuser  = out_sts_q;
	assign m_axis_tdata  = {(OUT_TDATA_W - WORD_W - 2 - FREE_W)'(0), out_free_q, out_full_q,
		out_empty_q, out_rdata_q};

	// ---------------------------------------------------------------------
	// Assertions
	a_accept_to_exec: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> state_q == ST_EXEC)
		else $error("accepted request did not enter execute");

	a_finish_loads: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FINISH && out_free) |=> out_valid_q)
		else $error("finished response not loaded into output register");

	a_bad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_sts_q == STS_BAD_QUEUE) |->
		(out_rdata_q == '0 && !out_empty_q && !out_full_q && out_free_q == '0))
		else $error("bad-queue response carries nonzero fields");

	a_not_empty_and_full: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> !(out_empty_q && out_full_q))
		else $error("queue reported empty and full at once");

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
// Self-checking bench for multi_queue_fifo_engine_core: directed table, then random queue traffic.
// A queue-state predictor checks every response that the table does not pin. Depends on mqfe_pkg and the core RTL.

module testbench;
	import mqfe_pkg::*;

	localparam logic [2:0] REQ_UNUSED  = 3'd7;
	localparam int         HOLD_CYCLES = 300;
	localparam int         STALL_LIMIT = 3000;
	localparam int         NUM_PHASES  = 6;

	typedef struct packed {
		status_t     sts;
		logic [63:0] rdata;
		logic        empty;
		logic        full;
		logic [6:0]  free;
	} resp_t;

	typedef struct packed {
		logic [2:0]  kind;
		logic [7:0]  qid;
		logic [7:0]  tid;
		logic [63:0] wd;
		logic        pinned;
		resp_t       resp;
	} dir_row_t;

	localparam resp_t PREDICTED = '0;
	localparam logic [63:0] ONES = 64'hFFFF_FFFF_FFFF_FFFF;

	// Reset settings: one queue of depth 8. Pinned rows carry an expected response.
	localparam dir_row_t DIR_TABLE [26] = '{
		'{REQ_PRODUCE,    8'd0,   8'd5,   ONES,  1'b1, '{STS_NOT_OWNER, 64'd0, 1'b1, 1'b0, 7'd7}},
		'{REQ_CONSUME,    8'd0,   8'd5,   64'd0, 1'b1, '{STS_NOT_OWNER, 64'd0, 1'b1, 1'b0, 7'd7}},
		'{REQ_PEEK,       8'd0,   8'd0,   64'd0, 1'b1, '{STS_EMPTY,     64'd0, 1'b1, 1'b0, 7'd7}},
		'{REQ_CLOSE_PROD, 8'd0,   8'd5,   64'd0, 1'b1, '{STS_NOT_OWNER, 64'd0, 1'b1, 1'b0, 7'd7}},
		'{REQ_OPEN_PROD,  8'd0,   8'd5,   64'd0, 1'b1, '{STS_OK,        64'd0, 1'b1, 1'b0, 7'd7}},
		'{REQ_OPEN_PROD,  8'd0,   8'd5,   64'd0, 1'b1, '{STS_BUSY,      64'd0, 1'b1, 1'b0, 7'd7}},
		'{REQ_OPEN_PROD,  8'd0,   8'd9,   64'd0, 1'b1, '{STS_BUSY,      64'd0, 1'b1, 1'b0, 7'd7}},
		'{REQ_OPEN_CONS,  8'd0,   8'd255, 64'd0, 1'b1, '{STS_OK,        64'd0, 1'b1, 1'b0, 7'd7}},
		'{REQ_OPEN_CONS,  8'd0,   8'd0,   64'd0, 1'b1, '{STS_BUSY,      64'd0, 1'b1, 1'b0, 7'd7}},
		'{REQ_PRODUCE,    8'd1,   8'd5,   ONES,  1'b1, '{STS_BAD_QUEUE, 64'd0, 1'b0, 1'b0, 7'd0}},
		'{REQ_PEEK,       8'd255, 8'd255, 64'd0, 1'b1, '{STS_BAD_QUEUE, 64'd0, 1'b0, 1'b0, 7'd0}},
		'{REQ_CONSUME,    8'd0,   8'd255, 64'd0, 1'b1, '{STS_EMPTY,     64'd0, 1'b1, 1'b0, 7'd7}},
		'{REQ_PRODUCE,    8'd0,   8'd5,   ONES,                  1'b0, PREDICTED},
		'{REQ_PRODUCE,    8'd0,   8'd5,   64'd0,                 1'b0, PREDICTED},
		'{REQ_PRODUCE,    8'd0,   8'd5,   64'h8000_0000_0000_0001, 1'b0, PREDICTED},
		'{REQ_PRODUCE,    8'd0,   8'd5,   64'h0123_4567_89AB_CDEF, 1'b0, PREDICTED},
		'{REQ_PRODUCE,    8'd0,   8'd5,   64'hFEDC_BA98_7654_3210, 1'b0, PREDICTED},
		'{REQ_PRODUCE,    8'd0,   8'd5,   64'h5555_5555_AAAA_AAAA, 1'b0, PREDICTED},
		'{REQ_PRODUCE,    8'd0,   8'd5,   64'h7FFF_FFFF_FFFF_FFFE, 1'b0, PREDICTED},
		'{REQ_PRODUCE,    8'd0,   8'd5,   ONES,  1'b1, '{STS_FULL,      64'd0, 1'b0, 1'b1, 7'd0}},
		'{REQ_PEEK,       8'd0,   8'd77,  64'd0,                 1'b0, PREDICTED},
		'{REQ_CONSUME,    8'd0,   8'd5,   64'd0, 1'b1, '{STS_NOT_OWNER, 64'd0, 1'b0, 1'b1, 7'd0}},
		'{REQ_CONSUME,    8'd0,   8'd255, 64'd0,                 1'b0, PREDICTED},
		'{REQ_UNUSED,     8'd0,   8'd3,   ONES,                  1'b0, PREDICTED},
		'{REQ_CLOSE_PROD, 8'd0,   8'd5,   64'd0,                 1'b0, PREDICTED},
		'{REQ_CLOSE_CONS, 8'd0,   8'd255, 64'd0,                 1'b0, PREDICTED}
	};

	localparam logic [8:0] PH_QCOUNT [NUM_PHASES] = '{9'd4, 9'd256, 9'd0, 9'd2, 9'd300, 9'd1};
	localparam logic [2:0] PH_DSEL   [NUM_PHASES] = '{3'd1, 3'd7, 3'd3, 3'd0, 3'd5, 3'd4};
	localparam int         PH_ITEMS  [NUM_PHASES] = '{400, 420, 40, 350, 350, 330};

	logic                   clk;
	logic                   arst_n;
	logic                   s_axis_tvalid;
	logic                   s_axis_tready;
	logic [IN_TDATA_W-1:0]  s_axis_tdata;
	logic [2:0]             s_axis_tuser;
	logic                   m_axis_tvalid;
	logic                   m_axis_tready;
	logic [OUT_TDATA_W-1:0] m_axis_tdata;
	logic [2:0]             m_axis_tuser;
	logic                   cfg_wr_en;
	logic                   cfg_index;
	logic [CFG_DATA_W-1:0]  cfg_wdata;

	multi_queue_fifo_engine_core uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tuser (s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tuser (m_axis_tuser),
		.cfg_wr_en    (cfg_wr_en),
		.cfg_index    (cfg_index),
		.cfg_wdata    (cfg_wdata)
	);

	initial clk = 1'b0;
	always #2 clk = ~clk;

	// Queue-state predictor
	logic [63:0] word_mem [NUM_QUEUES_DEF][MAX_DEPTH_DEF];
	int unsigned wr_ptr   [NUM_QUEUES_DEF];
	int unsigned rd_ptr   [NUM_QUEUES_DEF];
	owner_t      prod_own [NUM_QUEUES_DEF];
	owner_t      cons_own [NUM_QUEUES_DEF];
	int unsigned q_count;
	int unsigned depth_code;

	resp_t response_q [$];
	resp_t pin_resp;
	bit    pin_valid;
	bit    hold_req;
	int    send_idle_pct;
	int    recv_idle_pct;
	int    errors, n_sent, n_checked, n_full, n_empty, n_bad;

	function automatic int unsigned active_queues();
		return (q_count > NUM_QUEUES_DEF) ? NUM_QUEUES_DEF : q_count;
	endfunction

	function automatic int unsigned step_ptr(input int unsigned p, input int unsigned d);
		return (p + 1 >= d) ? 0 : p + 1;
	endfunction

	function automatic void clear_queues();
		for (int i = 0; i < NUM_QUEUES_DEF; i++) begin
			wr_ptr[i]   = 0;
			rd_ptr[i]   = 0;
			prod_own[i] = '0;
			cons_own[i] = '0;
		end
	endfunction

	function automatic resp_t serve_request(input logic [2:0] kind, input logic [7:0] qid,
			input logic [7:0] tid, input logic [63:0] wd);
		resp_t       r;
		int unsigned d, wp, rp, used;
		r.sts   = STS_OK;
		r.rdata = '0;
		r.empty = 1'b0;
		r.full  = 1'b0;
		r.free  = '0;
		if (qid >= active_queues()) begin
			r.sts = STS_BAD_QUEUE;
			return r;
		end
		d  = DEPTH_TABLE[depth_code];
		wp = wr_ptr[qid];
		rp = rd_ptr[qid];
		case (kind)
			REQ_PRODUCE: begin
				if (!prod_own[qid].vld || prod_own[qid].tid != tid)
					r.sts = STS_NOT_OWNER;
				else if (step_ptr(wp, d) == rp)
					r.sts = STS_FULL;
				else begin
					word_mem[qid][wp] = wd;
					wr_ptr[qid] = step_ptr(wp, d);
				end
			end
			REQ_CONSUME: begin
				if (!cons_own[qid].vld || cons_own[qid].tid != tid)
					r.sts = STS_NOT_OWNER;
				else if (wp == rp)
					r.sts = STS_EMPTY;
				else begin
					r.rdata = word_mem[qid][rp];
					rd_ptr[qid] = step_ptr(rp, d);
				end
			end
			REQ_PEEK: begin
				if (wp == rp) r.sts = STS_EMPTY;
				else r.rdata = word_mem[qid][rp];
			end
			REQ_OPEN_PROD: begin
				if (prod_own[qid].vld) r.sts = STS_BUSY;
				else prod_own[qid] = '{vld: 1'b1, tid: tid};
			end
			REQ_OPEN_CONS: begin
				if (cons_own[qid].vld) r.sts = STS_BUSY;
				else cons_own[qid] = '{vld: 1'b1, tid: tid};
			end
			REQ_CLOSE_PROD: begin
				if (!prod_own[qid].vld || prod_own[qid].tid != tid) r.sts = STS_NOT_OWNER;
				else prod_own[qid] = '0;
			end
			REQ_CLOSE_CONS: begin
				if (!cons_own[qid].vld || cons_own[qid].tid != tid) r.sts = STS_NOT_OWNER;
				else cons_own[qid] = '0;
			end
			default: ;
		endcase
		wp      = wr_ptr[qid];
		rp      = rd_ptr[qid];
		used    = (wp >= rp) ? wp - rp : wp + d - rp;
		r.empty = (wp == rp);
		r.full  = (step_ptr(wp, d) == rp);
		r.free  = 7'(d - 1 - used);
		return r;
	endfunction

	task automatic check_field(input string name, input logic [63:0] want, input logic [63:0] got);
		if (want !== got) begin
			$display("%0t ns: %s mismatch, expected %h, got %h", $time, name, want, got);
			errors++;
		end
	endtask

	// Check the response first: it always belongs to an older request.
	always @(posedge clk) begin : scoreboard
		resp_t want;
		resp_t pred;
		if (m_axis_tvalid && m_axis_tready) begin
			n_checked++;
			if (m_axis_tuser == STS_FULL)      n_full++;
			if (m_axis_tuser == STS_EMPTY)     n_empty++;
			if (m_axis_tuser == STS_BAD_QUEUE) n_bad++;
			if (response_q.size() == 0) begin
				$display("%0t ns: response with none outstanding, got status %0d data %h",
					$time, m_axis_tuser, m_axis_tdata);
				errors++;
			end else begin
				want = response_q.pop_front();
				check_field("status",     want.sts,   m_axis_tuser);
				check_field("read_data",  want.rdata, m_axis_tdata[63:0]);
				check_field("empty flag", want.empty, m_axis_tdata[64]);
				check_field("is_full",    want.full,  m_axis_tdata[65]);
				check_field("free_slots", want.free,  m_axis_tdata[72:66]);
			end
		end
		if (s_axis_tvalid && s_axis_tready) begin
			pred = serve_request(s_axis_tuser, s_axis_tdata[7:0], s_axis_tdata[15:8],
				s_axis_tdata[79:16]);
			response_q.insert(response_q.size(), pin_valid ? pin_resp : pred);
			n_sent++;
		end
	end

	// Response sink: random backpressure, plus one long hold-off on request.
	initial begin : sink
		m_axis_tready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				m_axis_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
			end
			m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < STALL_LIMIT) begin
			@(posedge clk);
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || cfg_wr_en)
				quiet = 0;
			else
				quiet++;
		end
		$display("%0t ns: no transfer for %0d cycles", $time, STALL_LIMIT);
		$display("Some tests failed");
		$finish;
	end

	// Called at a falling edge; returns at the falling edge after the transfer.
	task automatic send_req(input logic [2:0] kind, input logic [7:0] qid, input logic [7:0] tid,
			input logic [63:0] wd);
		while ($urandom_range(99) < send_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser  <= kind;
		s_axis_tdata  <= {wd, tid, qid};
		@(posedge clk);
		while (!(s_axis_tvalid && s_axis_tready)) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic drain();
		s_axis_tvalid <= 1'b0;
		while (response_q.size() != 0) @(negedge clk);
		repeat (6) @(negedge clk);
	endtask

	task automatic write_reg(input cfg_reg_t idx, input logic [8:0] val);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(negedge clk);
		cfg_wr_en <= 1'b0;
		if (idx == CFG_QUEUE_COUNT) q_count = val;
		else depth_code = val[2:0];
		clear_queues();
	endtask

	// Mostly owner traffic on a few hot queues; the rest is foreign threads and noise.
	task automatic next_request(input bit filling, output logic [2:0] kind,
			output logic [7:0] qid, output logic [7:0] tid, output logic [63:0] wd);
		int unsigned lim, hot, r, p_prod;
		lim    = active_queues();
		hot    = (lim > 3) ? 3 : lim;
		wd     = {$urandom, $urandom};
		p_prod = filling ? 45 : 15;
		r      = $urandom_range(99);
		if (lim == 0 || r < 4) qid = 8'($urandom_range(255));
		else if (r < 75)       qid = 8'($urandom_range(hot - 1));
		else                   qid = 8'($urandom_range(lim - 1));
		tid = 8'($urandom_range(255));
		r   = $urandom_range(99);
		if (!prod_own[qid].vld && r < 50)
			kind = REQ_OPEN_PROD;
		else if (!cons_own[qid].vld && r < 50)
			kind = REQ_OPEN_CONS;
		else if (r < p_prod) begin
			kind = REQ_PRODUCE;
			tid  = prod_own[qid].tid;
		end else if (r < 60) begin
			kind = REQ_CONSUME;
			tid  = cons_own[qid].tid;
		end else if (r < 68)
			kind = REQ_PEEK;
		else if (r < 73) begin
			kind = r[0] ? REQ_PRODUCE : REQ_CONSUME;
			tid  = (r[0] ? prod_own[qid].tid : cons_own[qid].tid) ^ 8'($urandom_range(255, 1));
		end else if (r < 78)
			kind = r[0] ? REQ_OPEN_PROD : REQ_OPEN_CONS;
		else if (r < 85) begin
			kind = r[0] ? REQ_CLOSE_PROD : REQ_CLOSE_CONS;
			tid  = r[0] ? prod_own[qid].tid : cons_own[qid].tid;
		end else if (r < 90) begin
			kind = r[0] ? REQ_CLOSE_PROD : REQ_CLOSE_CONS;
			tid  = (r[0] ? prod_own[qid].tid : cons_own[qid].tid) ^ 8'($urandom_range(255, 1));
		end else if (r < 93)
			kind = REQ_UNUSED;
		else
			kind = 3'($urandom_range(7));
	endtask

	initial begin : stimulus
		logic [2:0]  kind;
		logic [7:0]  qid;
		logic [7:0]  tid;
		logic [63:0] wd;
		int          sent;
		arst_n        = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = '0;
		s_axis_tuser  = '0;
		cfg_wr_en     = 1'b0;
		cfg_index     = 1'b0;
		cfg_wdata     = '0;
		hold_req      = 1'b0;
		pin_valid     = 1'b0;
		pin_resp      = '0;
		send_idle_pct = 12;
		recv_idle_pct = 58;
		errors        = 0;
		n_sent        = 0;
		n_checked     = 0;
		n_full        = 0;
		n_empty       = 0;
		n_bad         = 0;
		q_count       = 1;
		depth_code    = 0;
		clear_queues();
		repeat (9) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		for (int i = 0; i < $size(DIR_TABLE); i++) begin
			pin_valid = DIR_TABLE[i].pinned;
			pin_resp  = DIR_TABLE[i].resp;
			send_req(DIR_TABLE[i].kind, DIR_TABLE[i].qid, DIR_TABLE[i].tid, DIR_TABLE[i].wd);
			pin_valid = 1'b0;
		end

		for (int ph = 0; ph < NUM_PHASES; ph++) begin
			drain();
			write_reg(CFG_QUEUE_COUNT, PH_QCOUNT[ph]);
			write_reg(CFG_DEPTH_SEL, {6'd0, PH_DSEL[ph]});
			send_idle_pct = (ph < 2) ? 12 : (ph < 4) ? 58 : 0;
			recv_idle_pct = (ph < 2) ? 58 : (ph < 4) ? 12 : 0;
			sent = 0;
			// Take queue 0 from empty to full, ending on a full retry.
			if (active_queues() > 0) begin
				send_req(REQ_OPEN_PROD, 8'd0, 8'($urandom_range(255)), '0);
				send_req(REQ_OPEN_CONS, 8'd0, 8'($urandom_range(255)), '0);
				for (int k = 0; k < DEPTH_TABLE[depth_code]; k++)
					send_req(REQ_PRODUCE, 8'd0, prod_own[0].tid, {$urandom, $urandom});
				sent = DEPTH_TABLE[depth_code] + 2;
			end
			if (ph == 4) hold_req = 1'b1;
			for (; sent < PH_ITEMS[ph]; sent++) begin
				next_request(((sent / 40) % 2) == 0, kind, qid, tid, wd);
				send_req(kind, qid, tid, wd);
			end
		end
		drain();

		$display("Ran %0d requests over %0d register settings; %0d responses checked.",
			n_sent, NUM_PHASES + 1, n_checked);
		$display("Seen: %0d full retries, %0d empty retries, %0d refused queue ids.",
			n_full, n_empty, n_bad);
		if (errors == 0 && response_q.size() == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule

// ===== sim.f =====
hw/rtl/mqfe_pkg.sv
hw/rtl/mqfe_meta_store.sv
hw/rtl/mqfe_entry_ram.sv
hw/rtl/multi_queue_fifo_engine_core.sv
tb/testbench.sv
